/* design/i2cm_pkg.sv */
package i2cm_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW = 8;
    localparam logic [3:0] RESET_CLOCKS = 4'd9;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] device_code;
        logic       legacy;
        logic [7:0] reg_address;
        logic [8:0] length;
        logic [7:0] data_byte;
        logic       scl_level;
        logic       sda_level;
    } t_in;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic       stretch_timeout;
    } t_out;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } t_buf_req;

    localparam logic [2:0] MODE_LOAD  = 3'd1;
    localparam logic [2:0] MODE_READ  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_RESET = 3'd4;

    localparam logic [1:0] CFG_FREE    = 2'd0;
    localparam logic [1:0] CFG_STRETCH = 2'd1;
    localparam logic [1:0] CFG_POLL    = 2'd2;
    localparam logic [1:0] CFG_CHUNK   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOACK  = 2'd1;
    localparam logic [1:0] ST_WEDGED = 2'd2;

endpackage

/* design/i2c_master_block_transfer.sv */
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   t_in, one bus tick
// result    out        o_valid / i_stall   t_out, one per tick
// config    in         i_cfg_valid/o_cfg_ready  index, data
//
// One request is taken each clock while the result register is empty or
// being drained, so the sustained rate is one tick per clock.
// The write buffer is a 256-entry synchronous memory read ahead
// into a prefetch register holding the byte at the send pointer.
// Reset is synchronous and needs no clearing pass; a stalled result holds.
module i2c_master_block_transfer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  i2cm_pkg::t_in     i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output i2cm_pkg::t_out    o_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [11:0]       i_cfg_data
);
    import i2cm_pkg::*;

    logic [9:0]  r_free;
    logic [11:0] r_stretch;
    logic [7:0]  r_poll;
    logic [4:0]  r_chunk;
    logic        r_ovalid;
    logic        step;
    t_buf_req    req;
    logic [7:0]  rdata;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_ovalid && i_stall;
    assign step        = i_valid && !o_stall;
    assign o_valid     = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= 10'd60; r_stretch <= 12'd1000; r_poll <= 8'd100; r_chunk <= 5'd4;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FREE:    r_free <= i_cfg_data[9:0];
                    CFG_STRETCH: r_stretch <= i_cfg_data;
                    CFG_POLL:    r_poll <= i_cfg_data[7:0];
                    CFG_CHUNK:   r_chunk <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    i2cm_buf u_buf (
        .i_clk   (i_clk),
        .i_req   (req),
        .o_rdata (rdata)
    );

    i2cm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (i_item),
        .i_free    (r_free),
        .i_stretch (r_stretch),
        .i_poll    (r_poll),
        .i_chunk   (r_chunk),
        .i_rdata   (rdata),
        .o_req     (req),
        .o_res     (o_item)
    );

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && i_stall) |=> o_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped under stall");

endmodule

/* design/i2cm_buf.sv */
module i2cm_buf (
    input  logic                i_clk,
    input  i2cm_pkg::t_buf_req  i_req,
    output logic [7:0]          o_rdata
);
    import i2cm_pkg::*;

    logic [7:0] r_mem [BUF_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end
endmodule

/* design/i2cm_ctrl.sv */
module i2cm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cm_pkg::t_in      i_item,
    input  logic [9:0]         i_free,
    input  logic [11:0]        i_stretch,
    input  logic [7:0]         i_poll,
    input  logic [4:0]         i_chunk,
    input  logic [7:0]         i_rdata,
    output i2cm_pkg::t_buf_req o_req,
    output i2cm_pkg::t_out     o_res
);
    import i2cm_pkg::*;

    typedef enum logic [27:0] {
        PH_IDLE = 28'd1 << 0, PH_ST_SDA1 = 28'd1 << 1, PH_ST_SCL1 = 28'd1 << 2,
        PH_ST_SDA0 = 28'd1 << 3, PH_ST_SCL0 = 28'd1 << 4, PH_WB_SDA = 28'd1 << 5,
        PH_WB_SCL1 = 28'd1 << 6, PH_WB_SCL0 = 28'd1 << 7, PH_WB_ACKREL = 28'd1 << 8,
        PH_WB_ACKSCL1 = 28'd1 << 9, PH_WB_ACKSCL0 = 28'd1 << 10, PH_RB_SCL1 = 28'd1 << 11,
        PH_RB_SCL0 = 28'd1 << 12, PH_RB_LSCL1 = 28'd1 << 13, PH_RB_ASDA0 = 28'd1 << 14,
        PH_RB_ASCL1 = 28'd1 << 15, PH_RB_ASCL0 = 28'd1 << 16, PH_RB_ASDA1 = 28'd1 << 17,
        PH_SP_SCL0 = 28'd1 << 18, PH_SP_SDA0 = 28'd1 << 19, PH_SP_SCL1 = 28'd1 << 20,
        PH_SP_SDA1 = 28'd1 << 21, PH_FREE = 28'd1 << 22, PH_RS_REL = 28'd1 << 23,
        PH_RS_SCL0 = 28'd1 << 24, PH_RS_SCL1 = 28'd1 << 25, PH_RS_SDA0 = 28'd1 << 26,
        PH_RS_SDA1 = 28'd1 << 27
    } t_phase;

    typedef enum logic [3:0] {
        S_NONE, S_DEV, S_REG, S_REGFREE, S_RDEV, S_WDEV, S_WREG, S_WDATA,
        S_CHUNKEND, S_POLL, S_POLLRETRY, S_DRAIN, S_NEXTCHUNK, S_FAIL, S_OKEND
    } t_stage;

    t_phase r_phase, n_phase, p;
    t_stage r_stage, n_stage;
    logic [3:0]  r_bits, n_bits;
    logic [7:0]  r_shift, n_shift;
    logic [8:0]  r_left, n_left;
    logic [7:0]  r_addr, n_addr;
    logic [4:0]  r_cleft, n_cleft;
    logic [11:0] r_timer, n_timer;
    logic [7:0]  r_pcnt, n_pcnt;
    logic [7:0]  r_lptr, n_lptr;
    logic [7:0]  r_sptr, n_sptr;
    logic        r_saw, n_saw;
    logic        r_scl, n_scl, r_sda, n_sda;
    logic [7:0]  r_dev, n_dev;
    logic        r_leg, n_leg;
    logic        r_dvalid, n_dvalid;
    logic        r_data_pend, n_data_pend;
    t_out        r_res, n_res;

    logic [9:0]  free_eff;
    logic [11:0] str_eff;
    logic [7:0]  poll_eff;
    logic [4:0]  chunk_eff;
    logic [8:0]  c;
    logic        rise_ok;
    logic        last;
    logic [11:0] tinc;

    assign free_eff  = (i_free == '0) ? 10'd1 : i_free;
    assign str_eff   = (i_stretch == '0) ? 12'd1 : i_stretch;
    assign poll_eff  = (i_poll == '0) ? 8'd1 : i_poll;
    assign chunk_eff = (i_chunk == '0) ? 5'd1 : ((i_chunk > 5'd16) ? 5'd16 : i_chunk);
    assign o_res     = r_res;

    // The next data byte is prefetched from the buffer ahead of its use, so
    // a byte has already been read from memory when it goes onto the bus.
    always_comb begin
        n_phase = r_phase; n_stage = r_stage; n_bits = r_bits; n_shift = r_shift;
        n_left = r_left; n_addr = r_addr; n_cleft = r_cleft; n_timer = r_timer;
        n_pcnt = r_pcnt; n_lptr = r_lptr; n_sptr = r_sptr; n_saw = r_saw;
        n_scl = r_scl; n_sda = r_sda; n_dev = r_dev; n_leg = r_leg;
        n_dvalid = r_dvalid; n_data_pend = 1'b0;
        n_res = r_res; o_req = '0;
        c = '0; rise_ok = 1'b0; last = 1'b0; tinc = r_timer + 12'd1;
        n_res.read_valid = 1'b0; n_res.read_data = '0; n_res.read_last = 1'b0;
        n_res.done_res = 1'b0; n_res.status = ST_OK; n_res.stretch_timeout = 1'b0;
        o_req.raddr = r_sptr;
        p = r_phase;
        if (i_step) begin
            if (r_data_pend) begin
                n_shift = i_rdata;
            end
            if (r_phase == PH_IDLE) begin
                case (i_item.mode)
                    MODE_LOAD: begin
                        o_req.we = 1'b1; o_req.waddr = r_lptr;
                        o_req.wdata = i_item.data_byte; n_lptr = r_lptr + 8'd1;
                    end
                    MODE_READ, MODE_WRITE: begin
                        n_dev = i_item.device_code; n_leg = i_item.legacy;
                        n_addr = i_item.reg_address; n_left = i_item.length;
                        if (i_item.length == '0) begin
                            n_res.done_res = 1'b1; n_stage = S_NONE;
                        end else if (i_item.mode == MODE_READ) begin
                            n_stage = i_item.legacy ? S_RDEV : S_DEV;
                            n_shift = i_item.legacy ? {i_item.reg_address[6:0], 1'b1}
                                                    : {i_item.device_code[7:1], 1'b0};
                            n_bits = 4'd8; p = PH_ST_SDA1;
                        end else begin
                            n_sptr = '0; n_lptr = '0; n_stage = S_WDEV;
                            n_shift = i_item.legacy ? {i_item.reg_address[6:0], 1'b0}
                                                    : {i_item.device_code[7:1], 1'b0};
                            n_bits = 4'd8; p = PH_ST_SDA1;
                        end
                    end
                    MODE_RESET: p = PH_RS_REL;
                    default: ;
                endcase
                o_req.raddr = n_sptr;
            end
            n_phase = p;
            if (p == PH_ST_SCL1 || p == PH_WB_SCL1 || p == PH_WB_ACKSCL1 || p == PH_RB_SCL1
                || p == PH_RB_LSCL1 || p == PH_RB_ASCL1 || p == PH_SP_SCL1
                || p == PH_RS_SCL1) begin
                if (!r_scl) begin
                    n_scl = 1'b1; n_timer = '0;
                end else if (i_item.scl_level) begin
                    rise_ok = 1'b1;
                end else begin
                    n_timer = tinc;
                    if (tinc >= str_eff) begin
                        n_res.stretch_timeout = 1'b1; rise_ok = 1'b1;
                    end
                end
            end
            case (p)
                PH_IDLE: ;
                PH_ST_SDA1: begin n_sda = 1'b1; n_phase = PH_ST_SCL1; end
                PH_ST_SCL1: if (rise_ok) n_phase = PH_ST_SDA0;
                PH_ST_SDA0: begin n_sda = 1'b0; n_phase = PH_ST_SCL0; end
                PH_ST_SCL0: begin n_scl = 1'b0; n_phase = PH_WB_SDA; end
                PH_WB_SDA: begin n_sda = r_shift[7]; n_phase = PH_WB_SCL1; end
                PH_WB_SCL1: if (rise_ok) n_phase = PH_WB_SCL0;
                PH_WB_SCL0: begin
                    n_scl = 1'b0; n_shift = {r_shift[6:0], 1'b0};
                    n_bits = (r_bits != '0) ? r_bits - 4'd1 : r_bits;
                    n_phase = (n_bits != '0) ? PH_WB_SDA : PH_WB_ACKREL;
                end
                PH_WB_ACKREL: begin n_sda = 1'b1; n_phase = PH_WB_ACKSCL1; end
                PH_WB_ACKSCL1: if (rise_ok) begin
                    n_saw = i_item.sda_level; n_phase = PH_WB_ACKSCL0;
                end
                PH_WB_ACKSCL0: begin
                    n_scl = 1'b0;
                    if (r_saw) begin
                        n_phase = PH_SP_SCL0;
                        if (r_stage == S_POLL) begin
                            n_pcnt = r_pcnt - 8'd1;
                            n_stage = (n_pcnt == '0) ? S_FAIL : S_POLLRETRY;
                        end else begin
                            n_stage = S_FAIL;
                        end
                    end else begin
                        case (r_stage)
                            S_DEV: begin
                                n_stage = S_REG; n_shift = r_addr; n_bits = 4'd8;
                                n_phase = PH_WB_SDA;
                            end
                            S_REG: begin
                                n_stage = S_REGFREE; n_timer = '0; n_phase = PH_FREE;
                            end
                            S_RDEV, S_POLL: begin
                                n_stage = (r_stage == S_POLL) ? S_DRAIN : S_RDEV;
                                n_shift = '0; n_bits = 4'd8; n_phase = PH_RB_SCL1;
                            end
                            S_WDEV, S_WREG, S_WDATA: begin
                                if (r_stage == S_WDEV && !r_leg) begin
                                    n_stage = S_WREG; n_shift = r_addr; n_bits = 4'd8;
                                    n_phase = PH_WB_SDA;
                                end else begin
                                    if (r_stage == S_WDATA) begin
                                        n_cleft = (r_cleft != '0) ? r_cleft - 5'd1 : r_cleft;
                                    end else begin
                                        c = ({4'd0, chunk_eff} > r_left) ? r_left
                                                                         : {4'd0, chunk_eff};
                                        n_cleft = c[4:0];
                                        n_addr = r_addr + c[7:0];
                                        n_left = r_left - c;
                                    end
                                    if (n_cleft != '0) begin
                                        n_stage = S_WDATA; n_shift = r_dvalid ? r_shift : i_rdata;
                                        n_data_pend = 1'b1; n_bits = 4'd8;
                                        n_sptr = r_sptr + 8'd1;
                                        o_req.raddr = n_sptr;
                                        n_phase = PH_WB_SDA;
                                    end else begin
                                        n_pcnt = poll_eff; n_stage = S_CHUNKEND;
                                        n_phase = PH_SP_SCL0;
                                    end
                                end
                            end
                            default: begin n_stage = S_FAIL; n_phase = PH_SP_SCL0; end
                        endcase
                    end
                end
                PH_RB_SCL1: if (rise_ok) begin
                    n_shift = {r_shift[6:0], i_item.sda_level}; n_phase = PH_RB_SCL0;
                end
                PH_RB_SCL0: begin
                    n_scl = 1'b0;
                    n_bits = (r_bits != '0) ? r_bits - 4'd1 : r_bits;
                    if (n_bits != '0) begin
                        n_phase = PH_RB_SCL1;
                    end else begin
                        if (r_stage == S_DRAIN) begin
                            last = 1'b1;
                        end else begin
                            n_left = (r_left != '0) ? r_left - 9'd1 : r_left;
                            last = (n_left == '0);
                            n_res.read_valid = 1'b1; n_res.read_data = r_shift;
                            n_res.read_last = last;
                        end
                        n_phase = last ? PH_RB_LSCL1 : PH_RB_ASDA0;
                    end
                end
                PH_RB_LSCL1: if (rise_ok) begin
                    n_stage = (r_stage == S_DRAIN) ? S_NEXTCHUNK : S_OKEND;
                    n_phase = PH_SP_SCL0;
                end
                PH_RB_ASDA0: begin n_sda = 1'b0; n_phase = PH_RB_ASCL1; end
                PH_RB_ASCL1: if (rise_ok) n_phase = PH_RB_ASCL0;
                PH_RB_ASCL0: begin n_scl = 1'b0; n_phase = PH_RB_ASDA1; end
                PH_RB_ASDA1: begin
                    n_sda = 1'b1; n_shift = '0; n_bits = 4'd8; n_phase = PH_RB_SCL1;
                end
                PH_SP_SCL0: begin n_scl = 1'b0; n_phase = PH_SP_SDA0; end
                PH_SP_SDA0: begin n_sda = 1'b0; n_phase = PH_SP_SCL1; end
                PH_SP_SCL1: if (rise_ok) n_phase = PH_SP_SDA1;
                PH_SP_SDA1: begin n_sda = 1'b1; n_timer = '0; n_phase = PH_FREE; end
                PH_FREE: begin
                    n_timer = tinc;
                    if (tinc >= {2'd0, free_eff}) begin
                        n_phase = PH_IDLE;
                        case (r_stage)
                            S_REGFREE: begin
                                n_stage = S_RDEV; n_shift = {r_dev[7:1], 1'b1};
                                n_bits = 4'd8; n_phase = PH_ST_SDA1;
                            end
                            S_CHUNKEND, S_POLLRETRY: begin
                                n_stage = S_POLL; n_shift = {r_dev[7:1], 1'b1};
                                n_bits = 4'd8; n_phase = PH_ST_SDA1;
                            end
                            S_NEXTCHUNK: begin
                                if (r_left != '0) begin
                                    n_stage = S_WDEV;
                                    n_shift = r_leg ? {r_addr[6:0], 1'b0}
                                                    : {r_dev[7:1], 1'b0};
                                    n_bits = 4'd8; n_phase = PH_ST_SDA1;
                                end else begin
                                    n_stage = S_NONE; n_res.done_res = 1'b1;
                                end
                            end
                            S_FAIL: begin
                                n_stage = S_NONE; n_res.done_res = 1'b1;
                                n_res.status = ST_NOACK;
                            end
                            default: begin n_stage = S_NONE; n_res.done_res = 1'b1; end
                        endcase
                    end
                end
                PH_RS_REL: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_bits = RESET_CLOCKS; n_saw = 1'b0;
                    n_phase = PH_RS_SCL0;
                end
                PH_RS_SCL0: begin n_scl = 1'b0; n_phase = PH_RS_SCL1; end
                PH_RS_SCL1: if (rise_ok) begin
                    n_saw = r_saw | i_item.sda_level;
                    n_bits = (r_bits != '0) ? r_bits - 4'd1 : r_bits;
                    if (n_bits != '0) begin
                        n_phase = PH_RS_SCL0;
                    end else if (n_saw) begin
                        n_phase = PH_RS_SDA0;
                    end else begin
                        n_phase = PH_IDLE; n_stage = S_NONE; n_res.done_res = 1'b1;
                        n_res.status = ST_WEDGED;
                    end
                end
                PH_RS_SDA0: begin n_sda = 1'b0; n_phase = PH_RS_SDA1; end
                PH_RS_SDA1: begin
                    n_sda = 1'b1; n_stage = S_OKEND; n_timer = '0; n_phase = PH_FREE;
                end
                default: begin n_phase = PH_IDLE; n_stage = S_NONE; end
            endcase
            n_res.scl_release = n_scl; n_res.sda_release = n_sda;
            n_res.busy_res = (n_phase != PH_IDLE);
            o_req.re = 1'b1;
            n_dvalid = 1'b1;
        end
        if (n_data_pend) begin
            n_shift = r_dvalid ? r_shift : i_rdata;
        end
    end

    // The prefetch register holds the byte at the send pointer; it is reloaded
    // from the memory read port on the first clock without a step after a step.
    logic [7:0] r_pre;
    logic       r_pre_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_stage <= S_NONE; r_bits <= '0; r_shift <= '0;
            r_left <= '0; r_addr <= '0; r_cleft <= '0; r_timer <= '0; r_pcnt <= '0;
            r_lptr <= '0; r_sptr <= '0; r_saw <= 1'b0; r_scl <= 1'b1; r_sda <= 1'b1;
            r_dev <= '0; r_leg <= 1'b0; r_dvalid <= 1'b0; r_data_pend <= 1'b0;
            r_res <= '0; r_pre <= '0; r_pre_ok <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase; r_stage <= n_stage; r_bits <= n_bits; r_left <= n_left;
            r_addr <= n_addr; r_cleft <= n_cleft; r_timer <= n_timer; r_pcnt <= n_pcnt;
            r_lptr <= n_lptr; r_sptr <= n_sptr; r_saw <= n_saw; r_scl <= n_scl;
            r_sda <= n_sda; r_dev <= n_dev; r_leg <= n_leg; r_dvalid <= 1'b0;
            r_data_pend <= 1'b0; r_res <= n_res; r_pre_ok <= 1'b0;
            r_shift <= (n_data_pend) ? (r_pre_ok ? r_pre : i_rdata) : n_shift;
        end else begin
            if (!r_pre_ok) begin
                r_pre <= i_rdata; r_pre_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && i_step && r_phase == PH_IDLE) begin
            assert (r_stage == S_NONE) else $error("stage left set while idle");
        end
    end

    property p_done_idle;
        @(posedge i_clk) disable iff (!i_rst_n) r_res.done_res |-> !r_res.busy_res;
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("done while busy");

    property p_status_done;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_res.status != ST_OK) |-> r_res.done_res;
    endproperty
    a_status_done: assert property (p_status_done) else $error("status without done");

    property p_last_valid;
        @(posedge i_clk) disable iff (!i_rst_n) r_res.read_last |-> r_res.read_valid;
    endproperty
    a_last_valid: assert property (p_last_valid) else $error("last without data");

endmodule

/* tb/i2c_master_block_transfer_tb.sv */
`timescale 1ns / 1ps

module i2c_master_block_transfer_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] MODE_TICK = 3'd0;

    typedef enum int {
        P_IDLE, P_ST_SDA1, P_ST_SCL1, P_ST_SDA0, P_ST_SCL0,
        P_WB_SDA, P_WB_SCL1, P_WB_SCL0, P_WB_ACKREL, P_WB_ACKSCL1, P_WB_ACKSCL0,
        P_RB_SCL1, P_RB_SCL0, P_RB_LSCL1, P_RB_ASDA0, P_RB_ASCL1, P_RB_ASCL0, P_RB_ASDA1,
        P_SP_SCL0, P_SP_SDA0, P_SP_SCL1, P_SP_SDA1, P_FREE,
        P_RS_REL, P_RS_SCL0, P_RS_SCL1, P_RS_SDA0, P_RS_SDA1
    } bus_phase_e;

    typedef enum int {
        S_NONE, S_DEV, S_REG, S_REGFREE, S_RDEV, S_WDEV, S_WREG, S_WDATA,
        S_CHUNKEND, S_POLL, S_POLLRETRY, S_DRAIN, S_NEXTCHUNK, S_FAIL, S_OKEND
    } xfer_step_e;

    class i2c_tick_scoreboard;
        t_out         expected_ticks[$];
        bit [9:0]     free_ticks;
        bit [11:0]    stretch_ticks;
        bit [7:0]     poll_limit;
        bit [4:0]     chunk_size;
        bus_phase_e   phase;
        xfer_step_e   stage;
        bit [3:0]     bit_count;
        bit [7:0]     shift_reg;
        bit [8:0]     bytes_left;
        bit [7:0]     cur_address;
        bit [4:0]     chunk_left;
        bit [11:0]    tick_timer;
        bit [7:0]     poll_count;
        bit [7:0]     load_ptr;
        bit [7:0]     send_ptr;
        bit           saw_high;
        bit [7:0]     wbuf [256];
        bit           loaded [256];
        bit           scl_rel;
        bit           sda_rel;
        bit [7:0]     dev_code;
        bit           legacy_mode;
        t_out         cur;
        int           errors;
        int           mismatches;

        function new();
            free_ticks = 60; stretch_ticks = 1000; poll_limit = 100; chunk_size = 4;
            phase = P_IDLE; stage = S_NONE; bit_count = 0; shift_reg = 0; bytes_left = 0;
            cur_address = 0; chunk_left = 0; tick_timer = 0; poll_count = 0;
            load_ptr = 0; send_ptr = 0; saw_high = 0; scl_rel = 1; sda_rel = 1;
            dev_code = 0; legacy_mode = 0; errors = 0; mismatches = 0;
            foreach (loaded[i]) loaded[i] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_FREE:    free_ticks = data[9:0];
                CFG_STRETCH: stretch_ticks = data;
                CFG_POLL:    poll_limit = data[7:0];
                CFG_CHUNK:   chunk_size = data[4:0];
            endcase
        endfunction

        function int loaded_prefix();
            int n;
            n = 0;
            while (n < 256 && loaded[n]) n++;
            return n;
        endfunction

        function int unsigned at_least_one(int unsigned v);
            return (v != 0) ? v : 1;
        endfunction

        function void finish(logic [1:0] st);
            phase = P_IDLE; stage = S_NONE; cur.done_res = 1; cur.status = st;
        endfunction

        function void send_byte(bit [7:0] v, bit with_start);
            shift_reg = v; bit_count = 8;
            phase = with_start ? P_ST_SDA1 : P_WB_SDA;
        endfunction

        function void go_stop(xfer_step_e nxt);
            stage = nxt; phase = P_SP_SCL0;
        endfunction

        function void go_free(xfer_step_e nxt);
            stage = nxt; tick_timer = 0; phase = P_FREE;
        endfunction

        function void begin_read(xfer_step_e st);
            stage = st; shift_reg = 0; bit_count = 8; phase = P_RB_SCL1;
        endfunction

        function void send_data();
            bit [7:0] v;
            v = wbuf[send_ptr];
            send_ptr++;
            stage = S_WDATA;
            send_byte(v, 0);
        endfunction

        function void begin_chunk();
            int unsigned c;
            c = at_least_one(chunk_size);
            if (c > 16) c = 16;
            if (c > bytes_left) c = bytes_left;
            chunk_left = c;
            cur_address = cur_address + c[7:0];
            bytes_left = bytes_left - c[8:0];
            send_data();
        endfunction

        function void write_address();
            stage = S_WDEV;
            send_byte(legacy_mode ? {cur_address[6:0], 1'b0} : {dev_code[7:1], 1'b0}, 1);
        endfunction

        function void byte_done(bit ack);
            if (!ack) begin
                if (stage == S_POLL) begin
                    poll_count--;
                    go_stop(poll_count == 0 ? S_FAIL : S_POLLRETRY);
                end else begin
                    go_stop(S_FAIL);
                end
                return;
            end
            case (stage)
                S_DEV: begin
                    stage = S_REG; send_byte(cur_address, 0);
                end
                S_REG: go_free(S_REGFREE);
                S_RDEV: begin_read(S_RDEV);
                S_WDEV: begin
                    if (legacy_mode) begin
                        begin_chunk();
                    end else begin
                        stage = S_WREG; send_byte(cur_address, 0);
                    end
                end
                S_WREG: begin_chunk();
                S_WDATA: begin
                    if (chunk_left > 0) chunk_left--;
                    if (chunk_left > 0) begin
                        send_data();
                    end else begin
                        poll_count = at_least_one(poll_limit);
                        go_stop(S_CHUNKEND);
                    end
                end
                S_POLL: begin_read(S_DRAIN);
                default: go_stop(S_FAIL);
            endcase
        endfunction

        function void after_free();
            case (stage)
                S_REGFREE: begin
                    stage = S_RDEV; send_byte({dev_code[7:1], 1'b1}, 1);
                end
                S_CHUNKEND, S_POLLRETRY: begin
                    stage = S_POLL; send_byte({dev_code[7:1], 1'b1}, 1);
                end
                S_NEXTCHUNK: begin
                    if (bytes_left > 0) write_address();
                    else finish(ST_OK);
                end
                S_FAIL: finish(ST_NOACK);
                default: finish(ST_OK);
            endcase
        endfunction

        function bit rise(bit scl);
            if (!scl_rel) begin
                scl_rel = 1; tick_timer = 0; return 0;
            end
            if (scl) return 1;
            tick_timer++;
            if (tick_timer >= at_least_one(stretch_ticks)) begin
                cur.stretch_timeout = 1; return 1;
            end
            return 0;
        endfunction

        function void run(bit scl, bit sda);
            bit last;
            case (phase)
                P_ST_SDA1: begin sda_rel = 1; phase = P_ST_SCL1; end
                P_ST_SCL1: if (rise(scl)) phase = P_ST_SDA0;
                P_ST_SDA0: begin sda_rel = 0; phase = P_ST_SCL0; end
                P_ST_SCL0: begin scl_rel = 0; phase = P_WB_SDA; end
                P_WB_SDA: begin sda_rel = shift_reg[7]; phase = P_WB_SCL1; end
                P_WB_SCL1: if (rise(scl)) phase = P_WB_SCL0;
                P_WB_SCL0: begin
                    scl_rel = 0;
                    shift_reg = shift_reg << 1;
                    if (bit_count > 0) bit_count--;
                    phase = (bit_count != 0) ? P_WB_SDA : P_WB_ACKREL;
                end
                P_WB_ACKREL: begin sda_rel = 1; phase = P_WB_ACKSCL1; end
                P_WB_ACKSCL1: if (rise(scl)) begin saw_high = sda; phase = P_WB_ACKSCL0; end
                P_WB_ACKSCL0: begin scl_rel = 0; byte_done(saw_high == 0); end
                P_RB_SCL1: if (rise(scl)) begin
                    shift_reg = {shift_reg[6:0], sda}; phase = P_RB_SCL0;
                end
                P_RB_SCL0: begin
                    scl_rel = 0;
                    if (bit_count > 0) bit_count--;
                    if (bit_count != 0) begin
                        phase = P_RB_SCL1;
                    end else begin
                        if (stage == S_DRAIN) begin
                            last = 1;
                        end else begin
                            if (bytes_left > 0) bytes_left--;
                            last = (bytes_left == 0);
                            cur.read_valid = 1; cur.read_data = shift_reg; cur.read_last = last;
                        end
                        phase = last ? P_RB_LSCL1 : P_RB_ASDA0;
                    end
                end
                P_RB_LSCL1: if (rise(scl)) go_stop(stage == S_DRAIN ? S_NEXTCHUNK : S_OKEND);
                P_RB_ASDA0: begin sda_rel = 0; phase = P_RB_ASCL1; end
                P_RB_ASCL1: if (rise(scl)) phase = P_RB_ASCL0;
                P_RB_ASCL0: begin scl_rel = 0; phase = P_RB_ASDA1; end
                P_RB_ASDA1: begin sda_rel = 1; begin_read(stage); end
                P_SP_SCL0: begin scl_rel = 0; phase = P_SP_SDA0; end
                P_SP_SDA0: begin sda_rel = 0; phase = P_SP_SCL1; end
                P_SP_SCL1: if (rise(scl)) phase = P_SP_SDA1;
                P_SP_SDA1: begin sda_rel = 1; go_free(stage); end
                P_FREE: begin
                    tick_timer++;
                    if (tick_timer >= at_least_one(free_ticks)) after_free();
                end
                P_RS_REL: begin
                    scl_rel = 1; sda_rel = 1; bit_count = RESET_CLOCKS; saw_high = 0;
                    phase = P_RS_SCL0;
                end
                P_RS_SCL0: begin scl_rel = 0; phase = P_RS_SCL1; end
                P_RS_SCL1: if (rise(scl)) begin
                    saw_high |= sda;
                    if (bit_count > 0) bit_count--;
                    if (bit_count != 0) phase = P_RS_SCL0;
                    else if (saw_high) phase = P_RS_SDA0;
                    else finish(ST_WEDGED);
                end
                P_RS_SDA0: begin sda_rel = 0; phase = P_RS_SDA1; end
                P_RS_SDA1: begin sda_rel = 1; go_free(S_OKEND); end
                default: begin phase = P_IDLE; stage = S_NONE; end
            endcase
        endfunction

        function void note_request(t_in it);
            cur = '0;
            if (phase == P_IDLE) begin
                if (it.mode == MODE_LOAD) begin
                    wbuf[load_ptr] = it.data_byte;
                    loaded[load_ptr] = 1;
                    load_ptr++;
                end else if (it.mode == MODE_READ || it.mode == MODE_WRITE) begin
                    dev_code = it.device_code; legacy_mode = it.legacy;
                    cur_address = it.reg_address; bytes_left = it.length;
                    if (it.length == 0) begin
                        finish(ST_OK);
                    end else if (it.mode == MODE_READ) begin
                        if (it.legacy) begin
                            stage = S_RDEV; send_byte({it.reg_address[6:0], 1'b1}, 1);
                        end else begin
                            stage = S_DEV; send_byte({it.device_code[7:1], 1'b0}, 1);
                        end
                    end else begin
                        send_ptr = 0; load_ptr = 0;
                        write_address();
                    end
                end else if (it.mode == MODE_RESET) begin
                    phase = P_RS_REL;
                end
                if (phase != P_IDLE) run(it.scl_level, it.sda_level);
            end else begin
                run(it.scl_level, it.sda_level);
            end
            cur.scl_release = scl_rel;
            cur.sda_release = sda_rel;
            cur.busy_res = (phase != P_IDLE);
            expected_ticks.push_back(cur);
        endfunction

        function void check_result(t_out got);
            t_out exp;
            if (expected_ticks.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result %h", got);
                return;
            end
            exp = expected_ticks.pop_front();
            if (got.scl_release !== exp.scl_release || got.sda_release !== exp.sda_release
                || got.read_data !== exp.read_data || got.read_valid !== exp.read_valid
                || got.read_last !== exp.read_last || got.busy_res !== exp.busy_res
                || got.done_res !== exp.done_res || got.status !== exp.status
                || got.stretch_timeout !== exp.stretch_timeout) begin
                errors++;
                if (mismatches++ < 10)
                    $display("mismatch: expected %h got %h at %0t", exp, got, $realtime);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_item;
    logic        o_valid;
    logic        i_stall;
    t_out        o_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    i2c_tick_scoreboard sb;
    int burst_left;
    int gaps_on;
    int stall_style;
    int stall_run;
    int stretch_pct;
    int nack_pct;
    int sda_force;
    int ticks_sent;

    i2c_master_block_transfer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            case (stall_style)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: begin
                    i_stall <= !i_stall;
                    stall_run <= $urandom_range(0, 8);
                end
            endcase
        end
    end

    function automatic void drive_bus_levels(ref t_in it);
        it.scl_level = sb.scl_rel && ($urandom_range(0, 99) >= stretch_pct);
        if (sda_force >= 0) it.sda_level = sda_force[0];
        else if (sb.phase == P_WB_ACKSCL1) it.sda_level = ($urandom_range(0, 99) < nack_pct);
        else it.sda_level = $urandom_range(0, 1);
    endfunction

    function automatic t_in idle_tick();
        t_in it;
        it = t_in'({$urandom, $urandom});
        if ($urandom_range(0, 9) != 0) it.mode = MODE_TICK;
        drive_bus_levels(it);
        return it;
    endfunction

    task automatic send_request(t_in it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if (gaps_on != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(it);
        ticks_sent++;
    endtask

    task automatic run_command(logic [2:0] mode, logic [7:0] dev, logic leg,
                               logic [7:0] addr, logic [8:0] len, logic [7:0] data);
        t_in it;
        it = t_in'({$urandom, $urandom});
        it.mode = mode; it.device_code = dev; it.legacy = leg;
        it.reg_address = addr; it.length = len; it.data_byte = data;
        drive_bus_levels(it);
        send_request(it);
        while (sb.phase != P_IDLE) send_request(idle_tick());
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic configure(int free_t, int stretch_t, int poll_t, int chunk_t);
        drain_results();
        write_reg(CFG_FREE, free_t[11:0]);
        write_reg(CFG_STRETCH, stretch_t[11:0]);
        write_reg(CFG_POLL, poll_t[11:0]);
        write_reg(CFG_CHUNK, chunk_t[11:0]);
        gaps_on = $urandom_range(0, 3);
        stall_style = $urandom_range(0, 2);
    endtask

    task automatic random_command();
        int pick;
        int room;
        logic [8:0] len;
        pick = $urandom_range(0, 99);
        nack_pct = ($urandom_range(0, 9) < 7) ? 3 : (($urandom_range(0, 2) == 0) ? 90 : 30);
        stretch_pct = $urandom_range(0, 3) * 4;
        if (pick < 20) begin
            repeat ($urandom_range(1, 20))
                run_command(MODE_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 55) begin
            len = ($urandom_range(0, 19) == 0) ? 9'd0 : 9'($urandom_range(1, 5));
            run_command(MODE_READ, $urandom, $urandom, $urandom, len, $urandom);
        end else if (pick < 88) begin
            room = sb.loaded_prefix();
            len = ($urandom_range(0, 19) == 0) ? 9'd0 : 9'($urandom_range(1, room < 10 ? room : 10));
            run_command(MODE_WRITE, $urandom, $urandom, $urandom, len, $urandom);
        end else if (pick < 95) begin
            if ($urandom_range(0, 3) == 0) sda_force = 0;
            run_command(MODE_RESET, $urandom, $urandom, $urandom, $urandom, $urandom);
            sda_force = -1;
        end else begin
            run_command(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        repeat ($urandom_range(0, 3)) send_request(idle_tick());
    endtask

    initial begin
        int target;
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        burst_left = 0;
        gaps_on = 1;
        stall_style = 1;
        stall_run = 0;
        stretch_pct = 4;
        nack_pct = 3;
        sda_force = -1;
        ticks_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_command(MODE_LOAD, 0, 0, 0, 0, 8'h00);
        run_command(MODE_LOAD, 0, 0, 0, 0, 8'hFF);
        run_command(MODE_LOAD, 0, 0, 0, 0, 8'hA5);
        run_command(MODE_LOAD, 0, 0, 0, 0, 8'h5A);
        run_command(MODE_READ, 8'hA0, 0, 8'h10, 0, 0);
        run_command(MODE_WRITE, 8'hA0, 0, 8'h10, 0, 0);
        run_command(MODE_READ, 8'hFF, 0, 8'hFF, 2, 0);
        run_command(MODE_READ, 8'h00, 1, 8'hFF, 1, 0);
        run_command(MODE_WRITE, 8'hFF, 0, 8'hFE, 4, 0);
        run_command(MODE_WRITE, 8'h00, 1, 8'h7F, 3, 0);
        run_command(MODE_RESET, 0, 0, 0, 0, 0);
        sda_force = 0;
        run_command(MODE_RESET, 0, 0, 0, 0, 0);
        sda_force = -1;
        run_command(3'd5, 0, 0, 0, 0, 0);
        run_command(3'd6, 0, 0, 0, 0, 0);
        run_command(3'd7, 0, 0, 0, 0, 0);
        nack_pct = 100;
        run_command(MODE_READ, 8'h50, 0, 8'h00, 1, 0);
        nack_pct = 3;

        configure(1, 1, 1, 1);
        stretch_pct = 20;
        run_command(MODE_READ, 8'h51, 0, 8'h33, 2, 0);
        stretch_pct = 4;
        nack_pct = 0;
        run_command(MODE_WRITE, 8'h51, 0, 8'h40, 2, 0);
        repeat (256) run_command(MODE_LOAD, 0, 0, 0, 0, $urandom);
        run_command(MODE_READ, 8'h52, 0, 8'h00, 256, 0);
        configure(1, 1000, 255, 16);
        run_command(MODE_WRITE, 8'h52, 0, 8'h00, 256, 0);
        nack_pct = 3;

        target = ticks_sent + 1900;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: configure(60, 1000, 100, 4);
                1: configure(1023, 4095, 255, 16);
                2: configure(0, 0, 0, 0);
                3: configure(2, 3, 2, 31);
                default: configure($urandom_range(1, 12), $urandom_range(2, 20),
                                   $urandom_range(1, 6), $urandom_range(1, 20));
            endcase
            while (ticks_sent < target - (4 - p) * 380) begin
                random_command();
                if (p == 2 && $urandom_range(0, 9) == 0) drain_results();
            end
        end
        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
design/i2cm_pkg.sv
design/i2cm_buf.sv
design/i2cm_ctrl.sv
design/i2c_master_block_transfer.sv
tb/i2c_master_block_transfer_tb.sv
